### hdl/unix_time_to_date_with_dst_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Unix time to date unit
// Shared property wrappers clocked on the unit clock.
// ----------------------------------------------------------------------------
`ifndef UNIX_TIME_TO_DATE_WITH_DST_UNIT_ASSERT_SVH
`define UNIX_TIME_TO_DATE_WITH_DST_UNIT_ASSERT_SVH

// Property checked only outside reset.
`define UTD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every edge, reset included.
`define UTD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hdl/utd_pkg.sv
// ----------------------------------------------------------------------------
// Unix time to date package
// Shared widths, command and status types and calendar helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package utd_pkg;

   // Field widths.
   localparam int TS_W    = 32;
   localparam int SEC_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int WDAY_W  = 3;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 12;
   localparam int DAYS_W  = 16;
   localparam int STEP_W  = 1;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
   localparam logic [YEAR_W-1:0] CENTURY_NON_LEAP = 12'd2100;

   // Division passes: seconds, minutes, hours, then the weekday.
   // Each pass multiplies first, then forms the quotient and remainder.
   localparam logic [1:0] PASS_SEC  = 2'd0;
   localparam logic [1:0] PASS_MIN  = 2'd1;
   localparam logic [1:0] PASS_HOUR = 2'd2;
   localparam logic [1:0] PASS_WDAY = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       div_end;
      logic [1:0] pass;
      logic       year_step;
      logic       month_step;
      logic       finish;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic year_done;
      logic month_done;
   } dp_status_type;

   // Divisor used by each pass.
   function automatic logic [6:0] pass_divisor(input logic [1:0] pass);
      logic [6:0] d;
      case (pass)
         PASS_SEC:  d = 7'd60;
         PASS_MIN:  d = 7'd60;
         PASS_HOUR: d = 7'd24;
         PASS_WDAY: d = 7'd7;
         default:   d = 7'd60;
      endcase
      return d;
   endfunction

   // Scaled reciprocal of each divisor. The upper product bits give the exact
   // quotient over the input range of that pass: 60 with a shift of 37,
   // 24 with a shift of 36 and 7 with a shift of 32.
   function automatic logic [TS_W-1:0] pass_reciprocal(input logic [1:0] pass);
      logic [TS_W-1:0] r;
      case (pass)
         PASS_SEC:  r = 32'h8888_8889;
         PASS_MIN:  r = 32'h8888_8889;
         PASS_HOUR: r = 32'hAAAA_AAAB;
         PASS_WDAY: r = 32'h2492_4925;
         default:   r = 32'h8888_8889;
      endcase
      return r;
   endfunction

   // Gregorian leap rule over 1970..2106: 2100 is the only century year in range that is not leap.
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      return (year[1:0] == 2'b00) && (year != CENTURY_NON_LEAP);
   endfunction

   // Length of a month, with the month counted from 0.
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd0:    len = 5'd31;
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### hdl/utd_dp.sv
// ----------------------------------------------------------------------------
// Unix time to date datapath
// Reciprocal-multiply divider, year and month subtraction and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "unix_time_to_date_with_dst_unit_assert.svh"

module utd_dp (
   input  wire                             clock,
   input  wire                             reset,
   input  wire utd_pkg::dp_cmd_type        cmd,
   output utd_pkg::dp_status_type          status,
   input  wire [utd_pkg::TS_W-1:0]         req_timestamp,
   output logic [utd_pkg::SEC_W-1:0]       rsp_second_of_minute,
   output logic [utd_pkg::SEC_W-1:0]       rsp_minute_of_hour,
   output logic [utd_pkg::HOUR_W-1:0]      rsp_hour_of_day,
   output logic [utd_pkg::WDAY_W-1:0]      rsp_weekday,
   output logic [utd_pkg::DAY_W-1:0]       rsp_day_of_month,
   output logic [utd_pkg::MONTH_W-1:0]     rsp_month_number,
   output logic [utd_pkg::YEAR_W-1:0]      rsp_year_number,
   output logic                            rsp_dst_active
);
   import utd_pkg::*;

   logic [TS_W-1:0]    q_ff, q_in;
   logic [2*TS_W-1:0]  prod_ff, prod_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [SEC_W-1:0]   min_ff, min_in;
   logic [HOUR_W-1:0]  hour_ff, hour_in;
   logic [WDAY_W-1:0]  wday_ff, wday_in;
   logic [DAYS_W-1:0]  days_ff, days_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;

   logic [6:0]         divisor;
   logic [TS_W-1:0]    recip;
   logic [TS_W-1:0]    quot;
   logic [12:0]        quot_low_mul;
   logic [SEC_W-1:0]   rem_next;
   logic               leap;
   logic [8:0]         year_len;
   logic [DAY_W-1:0]   mlen;
   logic [DAY_W-1:0]   day_final;
   logic [MONTH_W-1:0] month_final;

   // US daylight saving test on the finished calendar fields.
   function automatic logic dst_flag(input logic [MONTH_W-1:0] month,
                                     input logic [DAY_W-1:0]   day,
                                     input logic [WDAY_W-1:0]  wday,
                                     input logic [HOUR_W-1:0]  hour);
      logic signed [6:0] prev_sun;
      logic              flag;
      prev_sun = $signed({2'b00, day}) - $signed({4'b0000, wday}) + 7'sd1;
      if (prev_sun < 7'sd1) begin
         prev_sun = 7'sd0;
      end
      if (month < 4'd3 || month > 4'd11) begin
         flag = 1'b0;
      end else if (month > 4'd3 && month < 4'd11) begin
         flag = 1'b1;
      end else if (month == 4'd3) begin
         // On or after the second Sunday of March at 02:00.
         if (prev_sun >= 7'sd8) begin
            if (day > 5'd14) begin
               flag = 1'b1;
            end else if (wday > 3'd1) begin
               flag = 1'b1;
            end else begin
               flag = (hour >= 5'd2);
            end
         end else begin
            flag = 1'b0;
         end
      end else begin
         // November: before the first Sunday, or that Sunday before 02:00.
         if (prev_sun > 7'sd0 && prev_sun < 7'sd8 && wday == 3'd1 && hour < 5'd2) begin
            flag = 1'b1;
         end else begin
            flag = (prev_sun == 7'sd0);
         end
      end
      return flag;
   endfunction

   // Quotient from the registered reciprocal product. The remainder is below
   // 64, so only the low bits of the dividend and of quotient times divisor count.
   always_comb begin
      divisor = pass_divisor(cmd.pass);
      recip   = pass_reciprocal(cmd.pass);
      case (cmd.pass)
         PASS_SEC:  quot = {5'd0, prod_ff[63:37]};
         PASS_MIN:  quot = {5'd0, prod_ff[63:37]};
         PASS_HOUR: quot = {4'd0, prod_ff[63:36]};
         PASS_WDAY: quot = prod_ff[63:32];
         default:   quot = prod_ff[63:32];
      endcase
      quot_low_mul = quot[SEC_W-1:0] * divisor;
      rem_next     = q_ff[SEC_W-1:0] - quot_low_mul[SEC_W-1:0];
   end

   // Year and month lengths for the subtraction loops.
   always_comb begin
      leap     = is_leap(year_ff);
      year_len = leap ? 9'd366 : 9'd365;
      mlen     = month_length(month_ff, leap);
      status.year_done  = (days_ff < {7'd0, year_len});
      status.month_done = (days_ff < {11'd0, mlen});
      day_final   = days_ff[DAY_W-1:0] + 5'd1;
      month_final = month_ff + 4'd1;
   end

   // Next values of the working registers.
   always_comb begin
      q_in     = q_ff;
      prod_in  = prod_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      wday_in  = wday_ff;
      days_in  = days_ff;
      year_in  = year_ff;
      month_in = month_ff;
      if (cmd.load) begin
         q_in     = req_timestamp;
         year_in  = EPOCH_YEAR;
         month_in = '0;
      end else if (cmd.div_step) begin
         if (cmd.div_end) begin
            q_in = quot;
            case (cmd.pass)
               PASS_SEC:  sec_in = rem_next;
               PASS_MIN:  min_in = rem_next;
               PASS_HOUR: begin
                  hour_in = rem_next[HOUR_W-1:0];
                  days_in = quot[DAYS_W-1:0];
                  // Day 0 was a Thursday; offset so that Sunday leaves remainder 0.
                  q_in    = quot + 32'd4;
               end
               PASS_WDAY: wday_in = rem_next[WDAY_W-1:0] + 3'd1;
               default:   sec_in = sec_ff;
            endcase
         end else begin
            prod_in = {32'd0, q_ff} * {32'd0, recip};
         end
      end else if (cmd.year_step) begin
         days_in = days_ff - {7'd0, year_len};
         year_in = year_ff + 12'd1;
      end else if (cmd.month_step) begin
         days_in  = days_ff - {11'd0, mlen};
         month_in = month_ff + 4'd1;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      prod_ff  <= prod_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hour_ff  <= hour_in;
      wday_ff  <= wday_in;
      days_ff  <= days_in;
      year_ff  <= year_in;
      month_ff <= month_in;
   end

   // Result registers, loaded when the word is finished.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_second_of_minute <= sec_ff;
         rsp_minute_of_hour   <= min_ff;
         rsp_hour_of_day      <= hour_ff;
         rsp_weekday          <= wday_ff;
         rsp_day_of_month     <= day_final;
         rsp_month_number     <= month_final;
         rsp_year_number      <= year_ff;
         rsp_dst_active       <= dst_flag(month_final, day_final, wday_ff, hour_ff);
      end
   end

   `UTD_ASSERT(a_month_range, cmd.finish |=> (rsp_month_number >= 4'd1 && rsp_month_number <= 4'd12), "month out of range")
   `UTD_ASSERT(a_load_year, cmd.load |=> (year_ff == EPOCH_YEAR && month_ff == 4'd0), "bad load of year and month")

endmodule

`default_nettype wire

### hdl/utd_ctrl.sv
// ----------------------------------------------------------------------------
// Unix time to date controller
// Sequences the division passes, the year loop and the month loop.
// ----------------------------------------------------------------------------
`default_nettype none
`include "unix_time_to_date_with_dst_unit_assert.svh"

module utd_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   output logic                      rsp_valid,
   output utd_pkg::dp_cmd_type       cmd,
   input  wire utd_pkg::dp_status_type status
);
   import utd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_YEAR,
      ST_MONTH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        pass_ff, pass_in;
   logic              valid_ff, valid_in;
   logic              last_step;

   // Commands and next state.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      pass_in   = pass_ff;
      valid_in  = 1'b0;
      last_step = (step_ff == {STEP_W{1'b1}});
      cmd       = '0;
      cmd.pass  = pass_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               step_in  = '0;
               pass_in  = PASS_SEC;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_end  = last_step;
            step_in      = step_ff + STEP_W'(1);
            if (last_step) begin
               pass_in = pass_ff + 2'd1;
               if (pass_ff == PASS_WDAY) begin
                  state_in = ST_YEAR;
               end
            end
         end
         ST_YEAR: begin
            if (status.year_done) begin
               state_in = ST_MONTH;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_MONTH: begin
            if (status.month_done) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         pass_ff  <= PASS_SEC;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pass_ff  <= pass_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   `UTD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
   `UTD_ASSERT(a_strobe_single, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `UTD_ASSERT(a_strobe_after_month, rsp_valid |-> $past(state_ff == ST_MONTH), "strobe without month step")
   `UTD_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> (!busy && !rsp_valid), "not idle after reset")

endmodule

`default_nettype wire

### hdl/unix_time_to_date_with_dst_unit.sv
// Sequence from the accepting edge to the result strobe: four reciprocal
// divisions, one year step per year past 1970, one month step per month
// before the result month, then the loop exits and the result register.
// A new word is accepted only while idle; busy drops in the strobe cycle.
// The receiver cannot stall; each result is shown for one cycle with rsp_valid.
// Synchronous reset returns the controller to idle and clears the strobe.
// ----------------------------------------------------------------------------
// Unix time to date with daylight saving
// Converts seconds since 1970 into calendar fields and a US DST flag.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_time_to_date_with_dst_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire [utd_pkg::TS_W-1:0]      req_timestamp,
   output logic                         rsp_valid,
   output logic [utd_pkg::SEC_W-1:0]    rsp_second_of_minute,
   output logic [utd_pkg::SEC_W-1:0]    rsp_minute_of_hour,
   output logic [utd_pkg::HOUR_W-1:0]   rsp_hour_of_day,
   output logic [utd_pkg::WDAY_W-1:0]   rsp_weekday,
   output logic [utd_pkg::DAY_W-1:0]    rsp_day_of_month,
   output logic [utd_pkg::MONTH_W-1:0]  rsp_month_number,
   output logic [utd_pkg::YEAR_W-1:0]   rsp_year_number,
   output logic                         rsp_dst_active
);
   import utd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Controller.
   utd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath.
   utd_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_timestamp        (req_timestamp),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_weekday          (rsp_weekday),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_number     (rsp_month_number),
      .rsp_year_number      (rsp_year_number),
      .rsp_dst_active       (rsp_dst_active)
   );

endmodule

`default_nettype wire
